// ===== hw/rtl/otrm_pkg.sv =====
// ----------------------------------------------------------------------------
// otrm_pkg
// Types and constants shared by the 1-wire temperature read master.
// ----------------------------------------------------------------------------
`default_nettype none

package otrm_pkg;

   localparam int NUM_REGS = 8;
   localparam int REG_W = 16;
   localparam int ADDR_W = 5;
   localparam int PHASE_W = 4;

   localparam logic [2:0] REG_RESET_LOW = 3'd0;
   localparam logic [2:0] REG_PRES_SAMPLE = 3'd1;
   localparam logic [2:0] REG_PRES_TAIL = 3'd2;
   localparam logic [2:0] REG_WRITE_LOW = 3'd3;
   localparam logic [2:0] REG_ONE_RELEASE = 3'd4;
   localparam logic [2:0] REG_SLOT_TAIL = 3'd5;
   localparam logic [2:0] REG_READ_SAMPLE = 3'd6;
   localparam logic [2:0] REG_POLL_PERIOD = 3'd7;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] otrm_regs_type;

   localparam otrm_regs_type REG_RESET_VALUES = {
      16'd65535, 16'd13, 16'd45, 16'd40, 16'd14, 16'd170, 16'd70, 16'd480
   };

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [2:0]         bit_idx;
      logic [3:0]         byte_idx;
      logic [7:0]         shift;
      logic [7:0]         crc;
      logic [4:0]         poll;
      logic               second;
      logic [1:0]         retry;
      logic [7:0]         sp0;
      logic [7:0]         sp1;
      logic [7:0]         sp5;
      logic [7:0]         sp7;
   } otrm_state_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        crc_failed;
      logic [1:0]  retry_cause;
      logic [15:0] temperature_word;
   } otrm_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/otrm_csr.sv =====
// ----------------------------------------------------------------------------
// otrm_csr
// APB-style register file holding the bus timing durations.
// ----------------------------------------------------------------------------
`default_nettype none

module otrm_csr (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire  [otrm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire  [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output otrm_pkg::otrm_regs_type   regs
);
   import otrm_pkg::*;

   otrm_regs_type regs_ff;
   otrm_regs_type regs_in;
   logic [2:0]    idx;

   assign idx = csr_paddr[ADDR_W-1:2];

   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         regs_in[idx] = csr_pwdata[REG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET_VALUES;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = {16'd0, regs_ff[idx]};
   assign csr_pready = 1'b1;
   assign regs = regs_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/otrm_core.sv =====
// ----------------------------------------------------------------------------
// otrm_core
// Sequencer state and single-tick step logic of the 1-wire read master.
// ----------------------------------------------------------------------------
`default_nettype none

module otrm_core #(
   parameter int POLL_LIMIT = 24,
   parameter int TIMER_BITS = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step_en,
   input  wire                      start_req,
   input  wire                      line_in,
   input  otrm_pkg::otrm_regs_type  regs,
   output otrm_pkg::otrm_result_type result
);
   import otrm_pkg::*;

   localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW = 4'd1;
   localparam logic [PHASE_W-1:0] PH_PRES_WAIT = 4'd2;
   localparam logic [PHASE_W-1:0] PH_PRES_TAIL = 4'd3;
   localparam logic [PHASE_W-1:0] PH_WR_LOW = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WR_ONE = 4'd5;
   localparam logic [PHASE_W-1:0] PH_WR_ZERO = 4'd6;
   localparam logic [PHASE_W-1:0] PH_POLL = 4'd7;
   localparam logic [PHASE_W-1:0] PH_RD_LOW = 4'd8;
   localparam logic [PHASE_W-1:0] PH_RD_WAIT = 4'd9;
   localparam logic [PHASE_W-1:0] PH_RD_TAIL = 4'd10;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT = 8'h44;
   localparam logic [7:0] CMD_READ_SP = 8'hBE;
   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam logic [15:0] CRC_FAIL_WORD = 16'hFFEE;

   localparam logic [1:0] CAUSE_NO_PRESENCE = 2'd1;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
   localparam logic [1:0] CAUSE_DEFAULT = 2'd3;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic otrm_state_type begin_pass(input otrm_state_type s, input logic pass);
      otrm_state_type r;
      r = s;
      r.second = pass;
      r.poll = '0;
      r.byte_idx = '0;
      r.bit_idx = '0;
      r.shift = '0;
      r.crc = '0;
      r.phase = PH_RST_LOW;
      return r;
   endfunction

   otrm_state_type        st_ff;
   otrm_state_type        st_in;
   logic [TIMER_BITS-1:0] tick_ff;
   logic [TIMER_BITS-1:0] tick_in;

   logic                  go;
   logic [PHASE_W-1:0]    phase_eff;
   logic [TIMER_BITS-1:0] tick_eff;
   logic [2:0]            reg_sel;
   logic [TIMER_BITS-1:0] dur_raw;
   logic [TIMER_BITS-1:0] dur;
   logic [TIMER_BITS-1:0] tick_inc;
   logic                  run_hit;
   logic [TIMER_BITS-1:0] tick_run;
   logic [7:0]            cmd;
   logic [15:0]           temp_raw;
   logic [4:0]            poll_inc;

   assign go = (st_ff.phase == PH_IDLE) && start_req;
   assign phase_eff = go ? PH_RST_LOW : st_ff.phase;
   assign tick_eff = go ? '0 : tick_ff;

   always_comb begin
      case (phase_eff)
         PH_RST_LOW:   reg_sel = REG_RESET_LOW;
         PH_PRES_WAIT: reg_sel = REG_PRES_SAMPLE;
         PH_PRES_TAIL: reg_sel = REG_PRES_TAIL;
         PH_WR_LOW:    reg_sel = REG_WRITE_LOW;
         PH_WR_ONE:    reg_sel = REG_ONE_RELEASE;
         PH_WR_ZERO:   reg_sel = REG_SLOT_TAIL;
         PH_POLL:      reg_sel = REG_POLL_PERIOD;
         PH_RD_WAIT:   reg_sel = REG_READ_SAMPLE;
         PH_RD_TAIL:   reg_sel = REG_SLOT_TAIL;
         default:      reg_sel = REG_RESET_LOW;
      endcase
   end

   assign dur_raw = TIMER_BITS'(regs[reg_sel]);
   assign dur = (dur_raw == '0) ? TIMER_BITS'(1) : dur_raw;
   assign tick_inc = tick_eff + TIMER_BITS'(1);
   assign run_hit = tick_inc >= dur;
   assign tick_run = run_hit ? '0 : tick_inc;
   assign poll_inc = st_ff.poll + 5'd1;

   assign cmd = (st_ff.byte_idx == 4'd0) ? CMD_SKIP_ROM :
                (st_ff.second ? CMD_READ_SP : CMD_CONVERT);
   assign temp_raw = {st_ff.sp1, st_ff.sp0};

   always_comb begin
      st_in = st_ff;
      tick_in = tick_ff;
      result = '0;
      if (go) begin
         st_in.retry = 2'd0;
         st_in = begin_pass(st_in, 1'b0);
         tick_in = '0;
      end
      case (phase_eff)
         PH_RST_LOW: begin
            result.drive_low = 1'b1;
            tick_in = tick_run;
            if (run_hit) begin
               st_in.phase = PH_PRES_WAIT;
            end
         end
         PH_PRES_WAIT: begin
            tick_in = tick_run;
            if (run_hit) begin
               st_in.shift = {7'd0, line_in};
               st_in.phase = PH_PRES_TAIL;
            end
         end
         PH_PRES_TAIL: begin
            tick_in = tick_run;
            if (run_hit) begin
               if (st_in.shift[0]) begin
                  st_in.retry = CAUSE_NO_PRESENCE;
                  st_in = begin_pass(st_in, 1'b0);
               end else begin
                  st_in.byte_idx = '0;
                  st_in.bit_idx = '0;
                  st_in.phase = PH_WR_LOW;
               end
            end
         end
         PH_WR_LOW: begin
            result.drive_low = 1'b1;
            tick_in = tick_run;
            if (run_hit) begin
               st_in.phase = cmd[st_in.bit_idx] ? PH_WR_ONE : PH_WR_ZERO;
            end
         end
         PH_WR_ONE, PH_WR_ZERO: begin
            result.drive_low = (phase_eff == PH_WR_ZERO);
            tick_in = tick_run;
            if (run_hit) begin
               if (st_in.bit_idx != 3'd7) begin
                  st_in.bit_idx = st_in.bit_idx + 3'd1;
                  st_in.phase = PH_WR_LOW;
               end else begin
                  st_in.bit_idx = '0;
                  if (st_in.byte_idx == 4'd0) begin
                     st_in.byte_idx = 4'd1;
                     st_in.phase = PH_WR_LOW;
                  end else if (!st_in.second) begin
                     st_in.poll = '0;
                     st_in.phase = PH_POLL;
                  end else begin
                     st_in.byte_idx = '0;
                     st_in.shift = '0;
                     st_in.crc = '0;
                     st_in.phase = PH_RD_LOW;
                  end
               end
            end
         end
         PH_POLL: begin
            if ((tick_eff == '0) && line_in) begin
               st_in = begin_pass(st_in, 1'b1);
               tick_in = '0;
            end else begin
               tick_in = tick_run;
               if (run_hit) begin
                  st_in.poll = poll_inc;
                  if (poll_inc >= 5'(POLL_LIMIT)) begin
                     st_in.retry = CAUSE_TIMEOUT;
                     st_in = begin_pass(st_in, 1'b0);
                  end
               end
            end
         end
         PH_RD_LOW: begin
            result.drive_low = 1'b1;
            st_in.phase = PH_RD_WAIT;
            tick_in = '0;
         end
         PH_RD_WAIT: begin
            tick_in = tick_run;
            if (run_hit) begin
               if (line_in) begin
                  st_in.shift[st_in.bit_idx] = 1'b1;
               end
               st_in.phase = PH_RD_TAIL;
            end
         end
         PH_RD_TAIL: begin
            tick_in = tick_run;
            if (run_hit) begin
               if (st_in.bit_idx != 3'd7) begin
                  st_in.bit_idx = st_in.bit_idx + 3'd1;
                  st_in.phase = PH_RD_LOW;
               end else if (st_in.byte_idx < 4'd8) begin
                  case (st_in.byte_idx)
                     4'd0:    st_in.sp0 = st_in.shift;
                     4'd1:    st_in.sp1 = st_in.shift;
                     4'd5:    st_in.sp5 = st_in.shift;
                     4'd7:    st_in.sp7 = st_in.shift;
                     default: st_in.sp0 = st_in.sp0;
                  endcase
                  st_in.crc = crc_byte(st_in.crc, st_in.shift);
                  st_in.byte_idx = st_in.byte_idx + 4'd1;
                  st_in.bit_idx = '0;
                  st_in.shift = '0;
                  st_in.phase = PH_RD_LOW;
               end else begin
                  st_in.bit_idx = '0;
                  if (st_in.crc != st_in.shift) begin
                     result.done_res = 1'b1;
                     result.crc_failed = 1'b1;
                     result.temperature_word = CRC_FAIL_WORD;
                     st_in.phase = PH_IDLE;
                  end else if (st_ff.sp0 == 8'h50 && st_ff.sp1 == 8'h05 &&
                               st_ff.sp5 == 8'hFF && st_ff.sp7 == 8'h10) begin
                     st_in.retry = CAUSE_DEFAULT;
                     st_in = begin_pass(st_in, 1'b0);
                  end else begin
                     result.done_res = 1'b1;
                     result.temperature_word = {{4{temp_raw[15]}}, temp_raw[15:4]};
                     st_in.phase = PH_IDLE;
                  end
                  tick_in = '0;
               end
            end
         end
         default: begin
            st_in.phase = PH_IDLE;
         end
      endcase
      result.busy_res = (st_in.phase != PH_IDLE);
      result.retry_cause = st_in.retry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         tick_ff <= '0;
      end else if (step_en) begin
         st_ff <= st_in;
         tick_ff <= tick_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/onewire_temperature_read_master_top.sv =====
// ----------------------------------------------------------------------------
// onewire_temperature_read_master_top
// 1-wire bus master that runs a complete temperature read, one tick per step.
// ----------------------------------------------------------------------------
// Each transaction on the req_ channel is one timer tick: the start request
// and the sampled bus level. Each tick yields exactly one transaction on the
// rsp_ channel carrying the drive level for that tick, the busy and done
// flags, the CRC status, the last restart cause and the temperature word.
// The tick is captured in an input register, the step logic is combinational
// between that register and the result register, and a tick's result is
// registered in the result register when the tick advances from the input
// register. One tick is taken every cycle while rsp_ready stays high, a rate
// set by the combinational step logic and the state registers it updates.
// When the receiver holds rsp_ready low the result register keeps its
// transaction and the input register fills; req_ready then drops until the
// result is taken. Reset is synchronous: the sequencer returns to idle, all
// counters clear and the timing registers on the csr_ port take their
// default values. The user must write timing registers through the csr_ port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_temperature_read_master_top #(
   parameter int POLL_LIMIT = 24,
   parameter int TIMER_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_start_req,
   input  wire         req_line_in,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_drive_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_crc_failed,
   output logic [1:0]  rsp_retry_cause,
   output logic [15:0] rsp_temperature_word,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [otrm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import otrm_pkg::*;

   otrm_regs_type   regs;
   otrm_result_type step_res;
   otrm_result_type rsp_ff;
   logic            rsp_vld_ff;
   logic            in_vld_ff;
   logic            in_start_ff;
   logic            in_line_ff;
   logic            advance;

   assign advance = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_start_ff <= req_start_req;
         in_line_ff <= req_line_in;
      end
   end

   otrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   otrm_core #(
      .POLL_LIMIT (POLL_LIMIT),
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .start_req (in_start_ff),
      .line_in   (in_line_ff),
      .regs      (regs),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_drive_low = rsp_ff.drive_low;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_crc_failed = rsp_ff.crc_failed;
   assign rsp_retry_cause = rsp_ff.retry_cause;
   assign rsp_temperature_word = rsp_ff.temperature_word;

endmodule

`default_nettype wire

// ===== hw/rtl/otrm_checker.sv =====
// ----------------------------------------------------------------------------
// otrm_checker
// Port-level checks of the 1-wire temperature read master, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module otrm_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        rsp_busy_res,
   input wire        rsp_done_res,
   input wire        rsp_crc_failed,
   input wire [15:0] rsp_temperature_word
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature_word);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result dropped while stalled");

   property p_done_not_busy;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_done_res |-> !rsp_busy_res;
   endproperty
   a_done_not_busy: assert property (p_done_not_busy) else $error("busy on done tick");

   property p_idle_fields;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_done_res |-> !rsp_crc_failed && rsp_temperature_word == 16'd0;
   endproperty
   a_idle_fields: assert property (p_idle_fields) else $error("result fields set without done");

   property p_crc_word;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_crc_failed |-> rsp_done_res && rsp_temperature_word == 16'hFFEE;
   endproperty
   a_crc_word: assert property (p_crc_word) else $error("bad word on CRC failure");

   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clear: assert property (p_reset_clear) else $error("result valid after reset");

endmodule

bind onewire_temperature_read_master_top otrm_checker u_otrm_checker (.*);

`default_nettype wire
